/* src/srr_pkg.sv */
// Shared constants for the selective-repeat receiver: field widths,
// default window/sequence parameters and result kind codes.
// No dependencies.
`timescale 1ns / 1ps

package srr_pkg;

   // Fixed field widths of the packet and result transactions
   localparam int SEQ_W     = 3;
   localparam int PAYLOAD_W = 64;

   // Default configuration of the receive window
   localparam int WINDOW_SIZE_DEF  = 4;
   localparam int SEQ_SPACE_DEF    = 8;
   localparam int PAYLOAD_BITS_DEF = 64;

   // Result kinds
   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

endpackage

/* src/srr_req_if.sv */
// Packet channel of the selective-repeat receiver: valid/ready plus the
// packet fields. Depends on srr_pkg.
`timescale 1ns / 1ps

interface srr_req_if;
   import srr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SEQ_W-1:0]     seq_num;
   logic                 checksum_ok;
   logic [PAYLOAD_W-1:0] payload_word;

   modport source (output valid, output seq_num, output checksum_ok,
                   output payload_word, input ready);
   modport sink   (input valid, input seq_num, input checksum_ok,
                   input payload_word, output ready);
endinterface

/* src/srr_rsp_if.sv */
// Result channel of the selective-repeat receiver: valid/ready plus the
// acknowledgement / delivery fields. Depends on srr_pkg.
`timescale 1ns / 1ps

interface srr_rsp_if;
   import srr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [SEQ_W-1:0]     ack_num;
   logic [PAYLOAD_W-1:0] delivered_payload;
   logic                 last;

   modport source (output valid, output kind, output ack_num,
                   output delivered_payload, output last, input ready);
   modport sink   (input valid, input kind, input ack_num,
                   input delivered_payload, input last, output ready);
endinterface

/* src/srr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/selective_repeat_receiver.sv */
// Selective-repeat receiver top level: window control, slot valid bits and
// result register around the slot payload RAM.
// Depends on srr_pkg, srr_req_if, srr_rsp_if and srr_ram.
//
// Usage:
//   req_chan carries one packet per transaction (sequence number, checksum
//   flag, payload). rsp_chan returns results: a good packet first yields an
//   acknowledgement carrying its sequence number, then, if it was the window
//   base, the in-order payloads that are now complete (up to WINDOW_SIZE).
//   The last flag marks the final result of a packet; a corrupt packet
//   yields no result.
//   Timing: a packet is taken and evaluated in the following cycle (ack
//   loaded, payload written to its slot). With deliveries, one slot RAM read
//   comes first, then one delivery per cycle while rsp_chan accepts results,
//   with the next read overlapped. Packets are handled one at a time.
//   A pending result sits in a single output register; a new packet may be
//   accepted while it waits. When rsp_chan stalls, evaluation or delivery
//   waits until the result register frees up.
//   Reset clears the window base and all slot valid bits; slot payloads stay.
`timescale 1ns / 1ps

module selective_repeat_receiver #(
   parameter int WINDOW_SIZE  = srr_pkg::WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   srr_req_if.sink   req_chan,
   srr_rsp_if.source rsp_chan
);
   import srr_pkg::*;

   localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int BASE_W = $clog2(SEQ_SPACE);
   localparam int DIST_W = ((BASE_W > SEQ_W) ? BASE_W : SEQ_W) + 1;
   localparam int REM_W  = SEQ_W + 1;

   // Control states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DELIV = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [SLOT_W-1:0]      bslot_ff, bslot_in;
   logic [WINDOW_SIZE-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Captured packet
   logic [SEQ_W-1:0]        seq_ff;
   logic                    ok_ff;
   logic [PAYLOAD_BITS-1:0] data_ff;

   // Result register payload
   logic                 kind_ff;
   logic [SEQ_W-1:0]     ack_ff;
   logic [PAYLOAD_W-1:0] dpay_ff;
   logic                 last_ff;

   logic                    accept;
   logic                    out_free;
   logic                    load;
   logic                    ld_kind;
   logic                    ld_last;
   logic [PAYLOAD_W-1:0]    ld_data;
   logic                    wr_en;
   logic                    rd_en;
   logic [SLOT_W-1:0]       rd_addr;
   logic [PAYLOAD_BITS-1:0] rd_data;

   logic                    seq_in_range;
   logic [DIST_W-1:0]       seq_x, base_x, win_off;
   logic                    in_win, at_base;
   logic [REM_W-1:0]        rem;
   logic [SLOT_W-1:0]       seq_slot;
   logic                    base_wrap;
   logic [BASE_W-1:0]       next_base;
   logic [SLOT_W-1:0]       next_slot;
   logic                    deliv_last;

   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Window distance of the captured sequence number
   always_comb begin
      seq_in_range = int'(seq_ff) < SEQ_SPACE;
      seq_x  = DIST_W'(seq_ff);
      base_x = DIST_W'(base_ff);
      if (seq_x >= base_x) begin
         win_off = seq_x - base_x;
      end else begin
         win_off = seq_x + DIST_W'(SEQ_SPACE) - base_x;
      end
      in_win  = seq_in_range && (int'(win_off) < WINDOW_SIZE);
      at_base = (win_off == '0);
   end

   // Slot of the sequence number: seq mod WINDOW_SIZE by repeated subtract
   always_comb begin
      rem = REM_W'(seq_ff);
      for (int i = 0; i < (1 << SEQ_W); i++) begin
         if (int'(rem) >= WINDOW_SIZE) begin
            rem = rem - REM_W'(WINDOW_SIZE);
         end
      end
      seq_slot = SLOT_W'(rem);
   end

   // Base advance; the slot pointer tracks base mod WINDOW_SIZE
   always_comb begin
      base_wrap = (base_ff == BASE_W'(SEQ_SPACE - 1));
      if (base_wrap) begin
         next_base = '0;
         next_slot = '0;
      end else begin
         next_base = base_ff + 1'b1;
         if (bslot_ff == SLOT_W'(WINDOW_SIZE - 1)) begin
            next_slot = '0;
         end else begin
            next_slot = bslot_ff + 1'b1;
         end
      end
      deliv_last = (cnt_ff == SLOT_W'(WINDOW_SIZE - 1)) || (next_slot == bslot_ff) ||
                   !valid_ff[next_slot];
   end

   // Control sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      bslot_in     = bslot_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      load         = 1'b0;
      ld_kind      = KIND_ACK;
      ld_last      = 1'b1;
      ld_data      = '0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = bslot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!ok_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               load    = 1'b1;
               ld_kind = KIND_ACK;
               ld_last = !(in_win && at_base);
               cnt_in  = '0;
               if (in_win && !valid_ff[seq_slot]) begin
                  wr_en              = 1'b1;
                  valid_in[seq_slot] = 1'b1;
               end
               state_in = (in_win && at_base) ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DELIV;
         end
         ST_DELIV: begin
            if (out_free) begin
               load               = 1'b1;
               ld_kind            = KIND_DATA;
               ld_last            = deliv_last;
               ld_data            = PAYLOAD_W'(rd_data);
               valid_in[bslot_ff] = 1'b0;
               base_in            = next_base;
               bslot_in           = next_slot;
               cnt_in             = cnt_ff + 1'b1;
               if (deliv_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = next_slot;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         bslot_ff     <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         bslot_ff     <= bslot_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Packet capture and result payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         seq_ff  <= req_chan.seq_num;
         ok_ff   <= req_chan.checksum_ok;
         data_ff <= req_chan.payload_word[PAYLOAD_BITS-1:0];
      end
      if (load) begin
         kind_ff <= ld_kind;
         ack_ff  <= (ld_kind == KIND_ACK) ? seq_ff : '0;
         dpay_ff <= ld_data;
         last_ff <= ld_last;
      end
   end

   // Slot payload store
   srr_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (WINDOW_SIZE),
      .ADDR_W(SLOT_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(seq_slot),
      .wr_data(data_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_chan.ready             = (state_ff == ST_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.kind              = kind_ff;
   assign rsp_chan.ack_num           = ack_ff;
   assign rsp_chan.delivered_payload = dpay_ff;
   assign rsp_chan.last              = last_ff;

endmodule

/* bench/srr_checker.sv */
// Result checker for the selective-repeat receiver: watches both channels,
// predicts acks and in-order deliveries, and counts mismatches.
// Depends on srr_pkg, srr_req_if and srr_rsp_if.
`timescale 1ns / 1ps

module srr_checker #(
   parameter int WINDOW_SIZE  = srr_pkg::WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   srr_req_if                        req_mon,
   srr_rsp_if                        rsp_mon,
   output int                        fail_count,
   output int                        results_due,
   output logic [srr_pkg::SEQ_W-1:0] base_hint
);
   import srr_pkg::*;

   typedef struct packed {
      logic                 kind;
      logic [SEQ_W-1:0]     ack_num;
      logic [PAYLOAD_W-1:0] payload;
      logic                 last;
   } srr_result_type;

   localparam logic [PAYLOAD_W-1:0] KEEP_MASK = (PAYLOAD_BITS >= PAYLOAD_W) ?
      {PAYLOAD_W{1'b1}} : ((64'd1 << PAYLOAD_BITS) - 64'd1);

   // Shadow receiver state
   int                   window_base;
   logic                 slot_full [WINDOW_SIZE];
   logic [PAYLOAD_W-1:0] slot_word [WINDOW_SIZE];
   srr_result_type       due_results [$];
   int                   reported;

   // Work out the results of one accepted packet: ack, then in-order deliveries
   task automatic receive_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                                 input logic [PAYLOAD_W-1:0] word);
      srr_result_type burst [WINDOW_SIZE+1];
      int             count;
      int             win_off;
      int             slot;
      int             n;
      if (!ok) return;   // corrupt packet: dropped silently
      burst[0] = '{kind: KIND_ACK, ack_num: seq, payload: '0, last: 1'b0};
      count = 1;
      if (int'(seq) < SEQ_SPACE) begin
         win_off = (int'(seq) + SEQ_SPACE - window_base) % SEQ_SPACE;
         if (win_off < WINDOW_SIZE) begin
            slot = int'(seq) % WINDOW_SIZE;
            // a duplicate keeps the first payload
            if (!slot_full[slot]) begin
               slot_full[slot] = 1'b1;
               slot_word[slot] = word & KEEP_MASK;
            end
            // base arrived: drain consecutive filled slots
            if (win_off == 0) begin
               for (n = 0; n < WINDOW_SIZE; n++) begin
                  slot = window_base % WINDOW_SIZE;
                  if (!slot_full[slot]) break;
                  burst[count] = '{kind: KIND_DATA, ack_num: '0,
                                   payload: slot_word[slot], last: 1'b0};
                  count++;
                  slot_full[slot] = 1'b0;
                  window_base = (window_base + 1) % SEQ_SPACE;
               end
            end
         end
      end
      burst[count-1].last = 1'b1;
      for (n = 0; n < count; n++) due_results = {due_results, burst[n]};
   endtask

   // Compare one result transaction against the oldest expectation
   task automatic check_result();
      srr_result_type want;
      if (due_results.size() == 0) begin
         fail_count++;
         if (reported < 10)
            $display("%0t: unexpected result kind=%0b ack=%0d data=%h last=%0b",
                     $realtime, rsp_mon.kind, rsp_mon.ack_num,
                     rsp_mon.delivered_payload, rsp_mon.last);
         reported++;
         return;
      end
      want = due_results.pop_front();
      if (rsp_mon.kind !== want.kind || rsp_mon.ack_num !== want.ack_num ||
          rsp_mon.delivered_payload !== want.payload || rsp_mon.last !== want.last) begin
         fail_count++;
         if (reported < 10)
            $display("%0t: exp k=%0b a=%0d d=%h l=%0b, got k=%0b a=%0d d=%h l=%0b",
                     $realtime, want.kind, want.ack_num, want.payload, want.last,
                     rsp_mon.kind, rsp_mon.ack_num, rsp_mon.delivered_payload,
                     rsp_mon.last);
         reported++;
      end
   endtask

   // Sample both channels at the rising edge; results first, so a packet
   // accepted on the same edge cannot satisfy an earlier result
   always @(posedge clock) begin
      if (reset) begin
         window_base = 0;
         for (int i = 0; i < WINDOW_SIZE; i++) slot_full[i] = 1'b0;
         due_results.delete();
         fail_count = 0;
         reported   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready)
            receive_packet(req_mon.seq_num, req_mon.checksum_ok, req_mon.payload_word);
      end
      results_due = due_results.size();
      base_hint   = window_base[SEQ_W-1:0];
   end

endmodule

/* bench/tb_top.sv */
// Top of the selective-repeat receiver bench: clock, reset, packet stimulus,
// random result back-pressure and the verdict.
// Depends on srr_pkg, the channel interfaces, the receiver and srr_checker.
`timescale 1ns / 1ps

module tb_top;
   import srr_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PACKETS = 410;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             sink_ready = 1'b0;
   logic             quiet = 1'b0;
   int               cycles = 0;
   int               fail_count;
   int               results_due;
   logic [SEQ_W-1:0] base_hint;

   srr_req_if req_chan ();
   srr_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   selective_repeat_receiver u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   srr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .results_due (results_due),
      .base_hint   (base_hint)
   );

   always #2 clock = ~clock;

   // Result side back-pressure, off during the quiet stretch
   always @(negedge clock) begin
      sink_ready <= !reset && (quiet || $urandom_range(99) >= 13);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One packet transaction; valid stays high across back-to-back packets
   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                              input logic [PAYLOAD_W-1:0] word);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 13) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.seq_num      = seq;
      req_chan.checksum_ok  = ok;
      req_chan.payload_word = word;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold the sender until every pending result has come out
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   initial begin
      int                   i;
      int                   pick;
      logic [SEQ_W-1:0]     seq;
      logic                 ok;
      logic [PAYLOAD_W-1:0] word;

      req_chan.valid        = 1'b0;
      req_chan.seq_num      = '0;
      req_chan.checksum_ok  = 1'b0;
      req_chan.payload_word = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: corrupt, duplicate, outside window, full drains, wrap of base
      send_packet(3'd0, 1'b0, 64'h0123_4567_89ab_cdef);
      send_packet(3'd1, 1'b1, 64'hffff_ffff_ffff_ffff);
      send_packet(3'd1, 1'b1, 64'h0);
      send_packet(3'd5, 1'b1, 64'h5555_5555_5555_5555);
      send_packet(3'd3, 1'b1, 64'h8000_0000_0000_0001);
      send_packet(3'd2, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
      send_packet(3'd0, 1'b1, 64'h0);
      send_packet(3'd7, 1'b1, 64'hdead_beef_cafe_f00d);
      send_packet(3'd6, 1'b1, 64'h1111_2222_3333_4444);
      send_packet(3'd5, 1'b1, 64'h7fff_ffff_ffff_fffe);
      send_packet(3'd5, 1'b0, 64'hffff_ffff_ffff_ffff);
      send_packet(3'd4, 1'b1, 64'hffff_ffff_ffff_ffff);
      send_packet(3'd4, 1'b1, 64'h0);
      send_packet(3'd0, 1'b0, 64'hffff_ffff_ffff_ffff);
      send_packet(3'd0, 1'b1, 64'ha5a5_5a5a_a5a5_5a5a);
      send_packet(3'd7, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f);
      send_packet(3'd1, 1'b1, 64'h0);
      send_packet(3'd2, 1'b1, 64'h1);
      send_packet(3'd3, 1'b1, 64'h2);
      send_packet(3'd4, 1'b1, 64'h3);

      // Random: mostly in-window traffic, plus corrupt, stale and stray packets
      for (i = 0; i < RANDOM_PACKETS; i++) begin
         quiet = (i >= 150 && i < 240);
         if (i == 320) wait_for_drain();
         pick = $urandom_range(99);
         ok   = 1'b1;
         if (pick < 10) begin
            seq = SEQ_W'($urandom_range(7));
            ok  = 1'b0;
         end else if (pick < 70) begin
            seq = base_hint + SEQ_W'($urandom_range(3));
         end else if (pick < 85) begin
            seq = base_hint + SEQ_W'($urandom_range(7, 4));
         end else begin
            seq = SEQ_W'($urandom_range(7));
            ok  = 1'($urandom_range(1));
         end
         pick = $urandom_range(99);
         if (pick < 5)       word = '0;
         else if (pick < 10) word = '1;
         else                word = {$urandom, $urandom};
         send_packet(seq, ok, word);
      end

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
